/* hdl/e2r_pkg.sv */
// e2r_pkg: shared widths, fixed-point constants, series tables and the
// sign-magnitude type for the Euler angle to rotation matrix pipeline.
// No dependencies.
package e2r_pkg;

    localparam int ANGLE_WIDTH = 16;
    localparam int ENTRY_WIDTH = 16;

    // Q30 working format
    localparam int              Q_FRAC       = 30;
    localparam logic [30:0]     Q_ONE        = 31'h4000_0000;
    localparam logic [63:0]     Q_HALF       = 64'd536870912;
    localparam logic signed [32:0] Q_PI         = 33'sd3373259426;
    localparam logic signed [32:0] Q_HALF_PI    = 33'sd1686629713;
    localparam logic signed [32:0] Q_QUARTER_PI = 33'sd843314857;

    // angle input: Q13, clamped to +/- pi
    localparam logic signed [32:0] ANGLE_LIMIT = 33'sd25736;
    localparam int                 ANGLE_SHIFT = Q_FRAC - 13;

    // entry output: Q14, rounded and saturated to +/- 1.0
    localparam int          ENTRY_SHIFT = Q_FRAC - 14;
    localparam logic [32:0] ENTRY_HALF  = 33'd1 << (ENTRY_SHIFT - 1);
    localparam longint      ENTRY_WMAX  = (64'sd1 <<< (ENTRY_WIDTH - 1)) - 1;
    localparam longint      ENTRY_HI    = (ENTRY_WMAX < 16384) ? ENTRY_WMAX : 16384;
    localparam longint      ENTRY_NLO   = (ENTRY_WMAX + 1 < 16384) ? ENTRY_WMAX + 1 : 16384;

    // Taylor series steps, sine first then cosine. Each step divides by a
    // constant through a reciprocal M = floor(2^k / d) plus one correction.
    localparam int SIN_STEPS    = 5;
    localparam int COS_STEPS    = 6;
    localparam int SERIES_STEPS = SIN_STEPS + COS_STEPS;
    localparam int STEP_STAGES  = 4;

    localparam int SERIES_DIV [SERIES_STEPS] =
        '{110, 72, 42, 20, 6, 132, 90, 56, 30, 12, 2};
    localparam int SERIES_SHIFT [SERIES_STEPS] =
        '{37, 37, 36, 35, 33, 38, 37, 36, 35, 34, 32};
    localparam logic [31:0] SERIES_RECIP [SERIES_STEPS] = '{
        32'((64'd1 << 37) / 64'd110),
        32'((64'd1 << 37) / 64'd72),
        32'((64'd1 << 36) / 64'd42),
        32'((64'd1 << 35) / 64'd20),
        32'((64'd1 << 33) / 64'd6),
        32'((64'd1 << 38) / 64'd132),
        32'((64'd1 << 37) / 64'd90),
        32'((64'd1 << 36) / 64'd56),
        32'((64'd1 << 35) / 64'd30),
        32'((64'd1 << 34) / 64'd12),
        32'((64'd1 << 32) / 64'd2)
    };

    // pipeline depths
    localparam int SIDE_DEPTH      = STEP_STAGES * COS_STEPS + 1;
    localparam int SV_DELAY        = STEP_STAGES * (COS_STEPS - SIN_STEPS);
    localparam int SINCOS_LATENCY  = 3 + STEP_STAGES * COS_STEPS + 1;
    localparam int MATRIX_LATENCY  = 7;
    localparam int TOTAL_LATENCY   = SINCOS_LATENCY + MATRIX_LATENCY;

    // Q30 value as magnitude and sign; sign is clear for a zero magnitude
    typedef struct packed {
        logic [30:0] mag;
        logic        neg;
    } sm_t;

    function automatic logic signed [31:0] sm_to_signed(input sm_t v);
        return v.neg ? -$signed({1'b0, v.mag}) : $signed({1'b0, v.mag});
    endfunction

endpackage

/* hdl/euler_to_rotation_matrix_top.sv */
// Euler angles (bank, attitude, heading) to 3x3 rotation matrix, fully pipelined.
// Throughput: one item per cycle; the whole pipeline advances together and
// halts only while the output holds an item and out_stall is high.
// Reset: rst_n, asynchronous, active low, clears the valid bits only.
// Depends on e2r_pkg, e2r_sincos, e2r_matrix.
module euler_to_rotation_matrix_top
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [e2r_pkg::ANGLE_WIDTH-1:0]  bank_angle,
    input  logic signed [e2r_pkg::ANGLE_WIDTH-1:0]  attitude_angle,
    input  logic signed [e2r_pkg::ANGLE_WIDTH-1:0]  heading_angle,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [e2r_pkg::ENTRY_WIDTH-1:0]  r00,
    output logic signed [e2r_pkg::ENTRY_WIDTH-1:0]  r01,
    output logic signed [e2r_pkg::ENTRY_WIDTH-1:0]  r02,
    output logic signed [e2r_pkg::ENTRY_WIDTH-1:0]  r10,
    output logic signed [e2r_pkg::ENTRY_WIDTH-1:0]  r11,
    output logic signed [e2r_pkg::ENTRY_WIDTH-1:0]  r12,
    output logic signed [e2r_pkg::ENTRY_WIDTH-1:0]  r20,
    output logic signed [e2r_pkg::ENTRY_WIDTH-1:0]  r21,
    output logic signed [e2r_pkg::ENTRY_WIDTH-1:0]  r22
);

    // Pipeline advance: every stage moves unless the last stage holds an
    // item that downstream refuses. Bubbles ahead still cannot be squeezed,
    // which keeps every stage a plain enabled register.
    logic en;
    logic [e2r_pkg::TOTAL_LATENCY-1:0] valid_reg;
    logic [e2r_pkg::TOTAL_LATENCY-1:0] valid_next;

    assign en         = !(valid_reg[e2r_pkg::TOTAL_LATENCY-1] && out_stall);
    assign in_stall   = !en;
    assign out_valid  = valid_reg[e2r_pkg::TOTAL_LATENCY-1];
    assign valid_next = {valid_reg[e2r_pkg::TOTAL_LATENCY-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // sine and cosine of each angle, Q30 sign-magnitude
    e2r_pkg::sm_t sb, cb, sa, ca, sh, ch;

    e2r_sincos u_bank
    (
        .clk     (clk),
        .en      (en),
        .angle   (bank_angle),
        .sin_val (sb),
        .cos_val (cb)
    );

    e2r_sincos u_attitude
    (
        .clk     (clk),
        .en      (en),
        .angle   (attitude_angle),
        .sin_val (sa),
        .cos_val (ca)
    );

    e2r_sincos u_heading
    (
        .clk     (clk),
        .en      (en),
        .angle   (heading_angle),
        .sin_val (sh),
        .cos_val (ch)
    );

    // matrix products; its last stage is the output register
    logic signed [e2r_pkg::ENTRY_WIDTH-1:0] entry [9];

    e2r_matrix u_matrix
    (
        .clk   (clk),
        .en    (en),
        .sb    (sb),
        .cb    (cb),
        .sa    (sa),
        .ca    (ca),
        .sh    (sh),
        .ch    (ch),
        .entry (entry)
    );

    assign r00 = entry[0];
    assign r01 = entry[1];
    assign r02 = entry[2];
    assign r10 = entry[3];
    assign r11 = entry[4];
    assign r12 = entry[5];
    assign r20 = entry[6];
    assign r21 = entry[7];
    assign r22 = entry[8];

`ifndef SYNTHESIS
    a_r00_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(r00) <= e2r_pkg::ENTRY_HI)
                   && ($signed(r00) >= -e2r_pkg::ENTRY_NLO))
        else $error("r00 outside saturation range");

    a_r22_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(r22) <= e2r_pkg::ENTRY_HI)
                   && ($signed(r22) >= -e2r_pkg::ENTRY_NLO))
        else $error("r22 outside saturation range");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while output item is blocked");

    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) |-> !in_stall)
        else $error("pipeline halted without a blocked output item");
`endif

endmodule

/* hdl/e2r_sincos.sv */
// e2r_sincos: pipelined sine and cosine of one Q13 angle, Q30 sign-magnitude out.
// Octant fold, then Horner Taylor series, four stages per series step.
// Depends on e2r_pkg.
module e2r_sincos
(
    input  logic                                     clk,
    input  logic                                     en,
    input  logic signed [e2r_pkg::ANGLE_WIDTH-1:0]  angle,
    output e2r_pkg::sm_t                             sin_val,
    output e2r_pkg::sm_t                             cos_val
);

    typedef struct packed {
        logic [29:0] t;
        logic [29:0] x;
        logic        uneg;
        logic        swap;
        logic        flip;
        logic        neg;
    } side_t;

    // stage A: clamp, magnitude, fold about pi/2
    logic signed [32:0] a_ext;
    logic [14:0]        a_mag;
    logic signed [32:0] m_s;
    logic               flip_a;
    logic signed [32:0] m2_reg;
    logic               flip_reg;
    logic               neg_reg;

    always_comb
    begin
        a_ext = 33'(angle);
        if (a_ext > e2r_pkg::ANGLE_LIMIT || a_ext < -e2r_pkg::ANGLE_LIMIT)
        begin
            a_mag = 15'(e2r_pkg::ANGLE_LIMIT);
        end
        else
        begin
            a_mag = a_ext[32] ? 15'(-a_ext) : 15'(a_ext);
        end
        m_s    = $signed(33'(a_mag) << e2r_pkg::ANGLE_SHIFT);
        flip_a = m_s > e2r_pkg::Q_HALF_PI;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_reg   <= flip_a ? e2r_pkg::Q_PI - m_s : m_s;
            flip_reg <= flip_a;
            neg_reg  <= a_ext[32];
        end
    end

    // stage B: fold about pi/4, kernel argument magnitude
    logic               swap_b;
    logic signed [32:0] xa_b;
    logic signed [32:0] xb_b;
    logic [29:0]        x_reg;
    logic               uneg_reg;
    logic               swap_reg;
    logic               flip_b_reg;
    logic               neg_b_reg;

    always_comb
    begin
        swap_b = m2_reg > e2r_pkg::Q_QUARTER_PI;
        xa_b   = e2r_pkg::Q_HALF_PI - m2_reg;
        xb_b   = m2_reg[32] ? -m2_reg : m2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg      <= swap_b ? 30'(xa_b) : 30'(xb_b);
            uneg_reg   <= !swap_b && m2_reg[32];
            swap_reg   <= swap_b;
            flip_b_reg <= flip_reg;
            neg_b_reg  <= neg_reg;
        end
    end

    // stage C: t = x^2, then sideband line alongside the series
    side_t side_reg [e2r_pkg::SIDE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{t:    30'((64'(x_reg) * 64'(x_reg) + e2r_pkg::Q_HALF)
                                       >> e2r_pkg::Q_FRAC),
                             x:    x_reg,
                             uneg: uneg_reg,
                             swap: swap_reg,
                             flip: flip_b_reg,
                             neg:  neg_b_reg};
            for (int i = 1; i < e2r_pkg::SIDE_DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // series steps: s = 1 - round(t*s) / d
    logic [30:0] n_reg  [e2r_pkg::SERIES_STEPS];
    logic [30:0] nn_reg [e2r_pkg::SERIES_STEPS];
    logic [62:0] nm_reg [e2r_pkg::SERIES_STEPS];
    logic [30:0] q_reg  [e2r_pkg::SERIES_STEPS];
    logic [8:0]  r_reg  [e2r_pkg::SERIES_STEPS];
    logic [30:0] s_reg  [e2r_pkg::SERIES_STEPS];

    for (genvar g = 0; g < e2r_pkg::SERIES_STEPS; g++)
    begin : g_step
        localparam int LI = (g < e2r_pkg::SIN_STEPS) ? g : g - e2r_pkg::SIN_STEPS;
        localparam int DIV = e2r_pkg::SERIES_DIV[g];
        localparam int SHF = e2r_pkg::SERIES_SHIFT[g];
        localparam logic [31:0] RCP = e2r_pkg::SERIES_RECIP[g];

        logic [30:0] s_in;
        logic [29:0] t_in;
        logic [30:0] q_c;

        if (LI == 0)
        begin : g_first
            assign s_in = e2r_pkg::Q_ONE;
        end
        else
        begin : g_next
            assign s_in = s_reg[g-1];
        end

        assign t_in = side_reg[e2r_pkg::STEP_STAGES * LI].t;
        assign q_c  = 31'(nm_reg[g] >> SHF);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[g]  <= 31'((64'(t_in) * 64'(s_in) + e2r_pkg::Q_HALF)
                                 >> e2r_pkg::Q_FRAC);
                nm_reg[g] <= 63'(64'(n_reg[g]) * 64'(RCP));
                nn_reg[g] <= n_reg[g];
                q_reg[g]  <= q_c;
                r_reg[g]  <= 9'(nn_reg[g] - 31'(32'(q_c) * 32'(DIV)));
                s_reg[g]  <= e2r_pkg::Q_ONE - q_reg[g] - 31'(r_reg[g] >= 9'(DIV));
            end
        end
    end

    // sine kernel: x * series, then held until the cosine series ends
    logic [29:0] sv_reg [e2r_pkg::SV_DELAY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv_reg[0] <= 30'((64'(side_reg[e2r_pkg::STEP_STAGES * e2r_pkg::SIN_STEPS].x)
                              * 64'(s_reg[e2r_pkg::SIN_STEPS-1]) + e2r_pkg::Q_HALF)
                             >> e2r_pkg::Q_FRAC);
            for (int i = 1; i < e2r_pkg::SV_DELAY; i++)
            begin
                sv_reg[i] <= sv_reg[i-1];
            end
        end
    end

    // unfold: swap roles past pi/4, cosine sign past pi/2, sine sign of angle
    side_t       sd;
    logic [30:0] ks;
    logic [30:0] kc;
    logic [30:0] s_mag;
    logic [30:0] c_mag;
    logic        s_neg;
    logic        c_neg;

    always_comb
    begin
        sd    = side_reg[e2r_pkg::SIDE_DEPTH-1];
        ks    = 31'(sv_reg[e2r_pkg::SV_DELAY-1]);
        kc    = s_reg[e2r_pkg::SERIES_STEPS-1];
        s_mag = sd.swap ? kc : ks;
        c_mag = sd.swap ? ks : kc;
        s_neg = ((sd.swap ? 1'b0 : sd.uneg) ^ sd.neg) && (s_mag != '0);
        c_neg = ((sd.swap ? sd.uneg : 1'b0) ^ sd.flip) && (c_mag != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_val <= '{mag: s_mag, neg: s_neg};
            cos_val <= '{mag: c_mag, neg: c_neg};
        end
    end

endmodule

/* hdl/e2r_matrix.sv */
// e2r_matrix: nine rotation matrix entries from three sine/cosine pairs.
// Two rounded product levels, sums, then Q14 rounding and saturation.
// Depends on e2r_pkg.
module e2r_matrix
(
    input  logic                                     clk,
    input  logic                                     en,
    input  e2r_pkg::sm_t                             sb,
    input  e2r_pkg::sm_t                             cb,
    input  e2r_pkg::sm_t                             sa,
    input  e2r_pkg::sm_t                             ca,
    input  e2r_pkg::sm_t                             sh,
    input  e2r_pkg::sm_t                             ch,
    output logic signed [e2r_pkg::ENTRY_WIDTH-1:0]  entry [9]
);

    // first level products
    localparam int P_CHCA = 0;
    localparam int P_SHSB = 1;
    localparam int P_CHSA = 2;
    localparam int P_CACB = 3;
    localparam int P_CASB = 4;
    localparam int P_SHCA = 5;
    localparam int P_SHSA = 6;
    localparam int P_CHSB = 7;
    localparam int P_SHCB = 8;
    localparam int P_CHCB = 9;
    localparam int NP1    = 10;

    // second level products
    localparam int Q_CSACB = 0;
    localparam int Q_CSASB = 1;
    localparam int Q_SSACB = 2;
    localparam int Q_SSASB = 3;
    localparam int NP2     = 4;

    e2r_pkg::sm_t op_a [NP1];
    e2r_pkg::sm_t op_b [NP1];

    always_comb
    begin
        op_a[P_CHCA] = ch; op_b[P_CHCA] = ca;
        op_a[P_SHSB] = sh; op_b[P_SHSB] = sb;
        op_a[P_CHSA] = ch; op_b[P_CHSA] = sa;
        op_a[P_CACB] = ca; op_b[P_CACB] = cb;
        op_a[P_CASB] = ca; op_b[P_CASB] = sb;
        op_a[P_SHCA] = sh; op_b[P_SHCA] = ca;
        op_a[P_SHSA] = sh; op_b[P_SHSA] = sa;
        op_a[P_CHSB] = ch; op_b[P_CHSB] = sb;
        op_a[P_SHCB] = sh; op_b[P_SHCB] = cb;
        op_a[P_CHCB] = ch; op_b[P_CHCB] = cb;
    end

    // L1: magnitude products
    logic [61:0]  p1_reg [NP1];
    logic         n1_reg [NP1];
    e2r_pkg::sm_t sa1_reg, sb1_reg, cb1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NP1; i++)
            begin
                p1_reg[i] <= 62'(op_a[i].mag) * 62'(op_b[i].mag);
                n1_reg[i] <= op_a[i].neg ^ op_b[i].neg;
            end
            sa1_reg <= sa;
            sb1_reg <= sb;
            cb1_reg <= cb;
        end
    end

    // L2: round half away from zero
    e2r_pkg::sm_t l2_reg [NP1];
    e2r_pkg::sm_t sa2_reg, sb2_reg, cb2_reg;
    logic [30:0]  m2 [NP1];

    always_comb
    begin
        for (int i = 0; i < NP1; i++)
        begin
            m2[i] = 31'((64'(p1_reg[i]) + e2r_pkg::Q_HALF) >> e2r_pkg::Q_FRAC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NP1; i++)
            begin
                l2_reg[i] <= '{mag: m2[i], neg: n1_reg[i] && (m2[i] != '0)};
            end
            sa2_reg <= sa1_reg;
            sb2_reg <= sb1_reg;
            cb2_reg <= cb1_reg;
        end
    end

    // L3: triple products, left to right
    e2r_pkg::sm_t op2_a [NP2];
    e2r_pkg::sm_t op2_b [NP2];
    logic [61:0]  p3_reg [NP2];
    logic         n3_reg [NP2];
    e2r_pkg::sm_t l3_reg [NP1];
    e2r_pkg::sm_t sa3_reg;

    always_comb
    begin
        op2_a[Q_CSACB] = l2_reg[P_CHSA]; op2_b[Q_CSACB] = cb2_reg;
        op2_a[Q_CSASB] = l2_reg[P_CHSA]; op2_b[Q_CSASB] = sb2_reg;
        op2_a[Q_SSACB] = l2_reg[P_SHSA]; op2_b[Q_SSACB] = cb2_reg;
        op2_a[Q_SSASB] = l2_reg[P_SHSA]; op2_b[Q_SSASB] = sb2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NP2; i++)
            begin
                p3_reg[i] <= 62'(op2_a[i].mag) * 62'(op2_b[i].mag);
                n3_reg[i] <= op2_a[i].neg ^ op2_b[i].neg;
            end
            l3_reg  <= l2_reg;
            sa3_reg <= sa2_reg;
        end
    end

    // L4: round triple products
    e2r_pkg::sm_t l4q_reg [NP2];
    e2r_pkg::sm_t l4_reg  [NP1];
    e2r_pkg::sm_t sa4_reg;
    logic [30:0]  m4 [NP2];

    always_comb
    begin
        for (int i = 0; i < NP2; i++)
        begin
            m4[i] = 31'((64'(p3_reg[i]) + e2r_pkg::Q_HALF) >> e2r_pkg::Q_FRAC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NP2; i++)
            begin
                l4q_reg[i] <= '{mag: m4[i], neg: n3_reg[i] && (m4[i] != '0)};
            end
            l4_reg  <= l3_reg;
            sa4_reg <= sa3_reg;
        end
    end

    // L5: entry sums in Q30
    logic signed [32:0] v5_reg [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v5_reg[0] <= 33'(e2r_pkg::sm_to_signed(l4_reg[P_CHCA]));
            v5_reg[1] <= 33'(e2r_pkg::sm_to_signed(l4_reg[P_SHSB]))
                       - 33'(e2r_pkg::sm_to_signed(l4q_reg[Q_CSACB]));
            v5_reg[2] <= 33'(e2r_pkg::sm_to_signed(l4q_reg[Q_CSASB]))
                       + 33'(e2r_pkg::sm_to_signed(l4_reg[P_SHCB]));
            v5_reg[3] <= 33'(e2r_pkg::sm_to_signed(sa4_reg));
            v5_reg[4] <= 33'(e2r_pkg::sm_to_signed(l4_reg[P_CACB]));
            v5_reg[5] <= -33'(e2r_pkg::sm_to_signed(l4_reg[P_CASB]));
            v5_reg[6] <= -33'(e2r_pkg::sm_to_signed(l4_reg[P_SHCA]));
            v5_reg[7] <= 33'(e2r_pkg::sm_to_signed(l4q_reg[Q_SSACB]))
                       + 33'(e2r_pkg::sm_to_signed(l4_reg[P_CHSB]));
            v5_reg[8] <= 33'(e2r_pkg::sm_to_signed(l4_reg[P_CHCB]))
                       - 33'(e2r_pkg::sm_to_signed(l4q_reg[Q_SSASB]));
        end
    end

    // L6: Q30 to Q14 magnitude, rounded half away from zero
    logic [17:0] p6_reg [9];
    logic        n6_reg [9];
    logic [32:0] mag6   [9];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            mag6[i] = v5_reg[i][32] ? 33'(-v5_reg[i]) : 33'(v5_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                p6_reg[i] <= 18'((mag6[i] + e2r_pkg::ENTRY_HALF) >> e2r_pkg::ENTRY_SHIFT);
                n6_reg[i] <= v5_reg[i][32];
            end
        end
    end

    // L7: sign and saturation
    logic signed [18:0] r7 [9];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            if (!n6_reg[i])
            begin
                r7[i] = (longint'(p6_reg[i]) > e2r_pkg::ENTRY_HI)
                      ? 19'(e2r_pkg::ENTRY_HI) : $signed({1'b0, p6_reg[i]});
            end
            else
            begin
                r7[i] = (longint'(p6_reg[i]) > e2r_pkg::ENTRY_NLO)
                      ? -19'(e2r_pkg::ENTRY_NLO) : -$signed({1'b0, p6_reg[i]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                entry[i] <= e2r_pkg::ENTRY_WIDTH'(r7[i]);
            end
        end
    end

endmodule

/* verif/euler_to_rotation_matrix_top_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for euler_to_rotation_matrix_top: random and corner angles,
// matrix entries predicted in Q30 fixed point. Depends on e2r_pkg and the top.
module euler_to_rotation_matrix_top_test;

    localparam int LATENCY     = 35;
    localparam int STALL_LIMIT = 20000;   // cycles with no item accepted or delivered
    localparam longint QONE    = 64'sd1073741824;
    localparam longint QHALFLSB = 64'sd536870912;
    localparam longint QPI     = 64'sd3373259426;
    localparam longint QPI2    = 64'sd1686629713;
    localparam longint QPI4    = 64'sd843314857;
    localparam int     ALIM    = 25736;

    typedef logic signed [e2r_pkg::ANGLE_WIDTH-1:0] angle_t;
    typedef logic signed [e2r_pkg::ENTRY_WIDTH-1:0] entry_t;

    typedef struct packed {
        angle_t bank;
        angle_t att;
        angle_t head;
    } angles_t;

    typedef struct packed {
        entry_t e00, e01, e02, e10, e11, e12, e20, e21, e22;
    } matrix_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    angle_t bank_angle, attitude_angle, heading_angle;
    logic out_valid;
    logic out_stall;
    entry_t r00, r01, r02, r10, r11, r12, r20, r21, r22;

    euler_to_rotation_matrix_top dut (.*);

    angles_t pending_angles[$];
    matrix_t expected_matrices[$];
    int      errors = 0;
    bit      stim_done = 0;
    int      idle_cycles = 0;
    int      in_gap = 0;
    int      out_hold = 0;
    int      total_items = 0;
    int      n_checked = 0;

    // ---------------------------------------------------------------
    // Fixed-point predictor: Q30 sine/cosine, products, Q14 entries
    // ---------------------------------------------------------------
    function automatic longint qmul(longint a, longint b);
        longint ma, mb, p;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p  = (ma * mb + QHALFLSB) >>> 30;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    // Taylor kernel, |u| <= pi/4
    task automatic series(input longint u, output longint sn, output longint cs);
        longint sin_div[5];
        longint cos_div[6];
        longint x, t, s, c, sv;
        sin_div = '{110, 72, 42, 20, 6};
        cos_div = '{132, 90, 56, 30, 12, 2};
        x = u < 0 ? -u : u;
        t = (x * x + QHALFLSB) >>> 30;
        s = QONE;
        c = QONE;
        for (int i = 0; i < 5; i++)
            s = QONE - ((t * s + QHALFLSB) >>> 30) / sin_div[i];
        for (int i = 0; i < 6; i++)
            c = QONE - ((t * c + QHALFLSB) >>> 30) / cos_div[i];
        sv = (x * s + QHALFLSB) >>> 30;
        sn = u < 0 ? -sv : sv;
        cs = c;
    endtask

    task automatic angle_sincos(input angle_t raw, output longint sn, output longint cs);
        longint a, m, s, c;
        bit flip;
        a = raw;
        flip = 0;
        if (a > ALIM) a = ALIM;
        if (a < -ALIM) a = -ALIM;
        m = (a < 0 ? -a : a) <<< 17;
        if (m > QPI2)
        begin
            m = QPI - m;
            flip = 1;
        end
        if (m > QPI4)
            series(QPI2 - m, c, s);
        else
            series(m, s, c);
        if (flip) c = -c;
        if (a < 0) s = -s;
        sn = s;
        cs = c;
    endtask

    function automatic entry_t q14(longint v);
        longint p, r, hi, lo, whi;
        p   = ((v < 0 ? -v : v) + (64'sd1 <<< 15)) >>> 16;
        r   = v < 0 ? -p : p;
        whi = (64'sd1 <<< (e2r_pkg::ENTRY_WIDTH - 1)) - 1;
        hi  = whi < 16384 ? whi : 16384;
        lo  = (-whi - 1) > -16384 ? (-whi - 1) : -16384;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return entry_t'(r);
    endfunction

    task automatic predict_matrix(input angles_t a, output matrix_t m);
        longint sb, cb, sa, ca, sh, ch;
        angle_sincos(a.bank, sb, cb);
        angle_sincos(a.att, sa, ca);
        angle_sincos(a.head, sh, ch);
        m.e00 = q14(qmul(ch, ca));
        m.e01 = q14(qmul(sh, sb) - qmul(qmul(ch, sa), cb));
        m.e02 = q14(qmul(qmul(ch, sa), sb) + qmul(sh, cb));
        m.e10 = q14(sa);
        m.e11 = q14(qmul(ca, cb));
        m.e12 = q14(-qmul(ca, sb));
        m.e20 = q14(-qmul(sh, ca));
        m.e21 = q14(qmul(qmul(sh, sa), cb) + qmul(ch, sb));
        m.e22 = q14(-qmul(qmul(sh, sa), sb) + qmul(ch, cb));
    endtask

    // gaps: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic angle_t rand_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return angle_t'($urandom);                 // any bit pattern
        if (r == 1) return angle_t'((($urandom_range(0, 8)) * 6434) - 25736 +
                                    $signed($urandom_range(0, 4)) - 2);
        return angle_t'($signed($urandom_range(0, 2 * ALIM)) - ALIM);
    endfunction

    // ---------------------------------------------------------------
    // Clock, reset and stimulus
    // ---------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        angle_t corners[$];
        angles_t item;
        corners = '{0, 1, -1, 25736, -25736, 25737, -25737, 16'sh7fff, 16'sh8000,
                    12868, -12868, 6434, -6434, 19302, 6435, 6433};
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        // directed: each corner on each axis, then mixed extremes
        foreach (corners[i])
            pending_angles.push_back('{corners[i], corners[(i + 3) % corners.size()],
                                       corners[(i + 7) % corners.size()]});
        pending_angles.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
        pending_angles.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
        pending_angles.push_back('{16'sh5555, 16'shaaaa, 16'sh0000});
        pending_angles.push_back('{16'shaaaa, 16'sh5555, 16'shffff});
        for (int n = 0; n < 600; n++)
        begin
            item.bank = rand_angle();
            item.att  = rand_angle();
            item.head = rand_angle();
            pending_angles.push_back(item);
        end
        total_items = pending_angles.size();
        stim_done = 1;
    end

    // ---------------------------------------------------------------
    // Driver: presents the head of the queue, holds it while stalled
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 0;
            bank_angle     <= '0;
            attitude_angle <= '0;
            heading_angle  <= '0;
            in_gap         <= 0;
        end
        else
        begin
            automatic bit busy = in_valid && in_stall;
            automatic matrix_t m;
            if (in_valid && !in_stall)
            begin
                predict_matrix('{bank_angle, attitude_angle, heading_angle}, m);
                expected_matrices.push_back(m);
            end
            if (!busy)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 0;
                    in_gap   <= in_gap - 1;
                end
                else if (pending_angles.size() > 0)
                begin
                    automatic angles_t a = pending_angles.pop_front();
                    in_valid       <= 1;
                    bank_angle     <= a.bank;
                    attitude_angle <= a.att;
                    heading_angle  <= a.head;
                    in_gap         <= pick_gap();
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random back-pressure, compare against the oldest entry
    // ---------------------------------------------------------------
    task automatic check_entry(string name, entry_t exp_v, entry_t act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            out_hold  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_matrices.size() == 0)
                begin
                    $display("%0t: unexpected item r00=%0d", $time, r00);
                    errors++;
                end
                else
                begin
                    automatic matrix_t e = expected_matrices.pop_front();
                    check_entry("r00", e.e00, r00);
                    check_entry("r01", e.e01, r01);
                    check_entry("r02", e.e02, r02);
                    check_entry("r10", e.e10, r10);
                    check_entry("r11", e.e11, r11);
                    check_entry("r12", e.e12, r12);
                    check_entry("r20", e.e20, r20);
                    check_entry("r21", e.e21, r21);
                    check_entry("r22", e.e22, r22);
                    n_checked++;
                end
            end
            if (out_hold > 0)
                out_hold <= out_hold - 1;
            else
            begin
                out_stall <= !out_stall ? ($urandom_range(0, 3) == 0) : 1'b0;
                out_hold  <= pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog and end of run
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        wait (stim_done && n_checked == total_items);
        // keep running to catch any extra item
        repeat (LATENCY * 2) @(posedge clk);
        if (errors == 0 && expected_matrices.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
